[sv/lrast_pkg.sv]
`default_nettype none

package lrast_pkg;

  localparam int unsigned CoordWidthDefault = 16;
  localparam logic [31:0] ColorReset        = 32'hEE4B2BFF;

  localparam logic ReqLoad    = 1'b0;
  localparam logic ReqAdvance = 1'b1;

endpackage

`default_nettype wire

[sv/line_rasterizer_unit.sv]
`default_nettype none
// Bresenham line rasteriser, all octants, endpoints included.
// An advance word's pixel reaches the output in the cycle after acceptance; a load gives none.
// One input word per cycle unless output stalls; a step is one or two adds and a compare.
// The output register is refilled in the cycle it is drained, so stalls cost nothing extra.
// Reset (rst_ni low, asynchronous): no line active, output empty, colour 0xEE4B2BFF.
module line_rasterizer_unit import lrast_pkg::*; #(
  parameter int unsigned CoordWidth = CoordWidthDefault
) (
  input  wire logic                                       clk_i,
  input  wire logic                                       rst_ni,
  // slave side
  input  wire logic                                       s_axis_tvalid_i,
  output logic                                            s_axis_tready_o,
  // start_x, start_y, end_x, end_y
  input  wire logic [((4*CoordWidth+7)/8)*8-1:0]          s_axis_tdata_i,
  // req_type
  input  wire logic                                       s_axis_tuser_i,
  // master side
  output logic                                            m_axis_tvalid_o,
  input  wire logic                                       m_axis_tready_i,
  // pix_x, pix_y, color
  output logic [((2*CoordWidth+32+7)/8)*8-1:0]            m_axis_tdata_o,
  output logic                                            m_axis_tlast_o,
  // colour register
  input  wire logic                                       cfg_we_i,
  input  wire logic [31:0]                                cfg_wdata_i
);

  localparam int unsigned W            = CoordWidth;
  localparam int unsigned EW           = CoordWidth + 3;
  localparam int unsigned OutBits      = 2 * CoordWidth + 32;
  localparam int unsigned OutDataWidth = ((OutBits + 7) / 8) * 8;

  logic [31:0]          color_q;
  logic                 active_q, active_d;
  logic [W-1:0]         cur_x_q, cur_x_d;
  logic [W-1:0]         cur_y_q, cur_y_d;
  logic [W-1:0]         maj_end_q, maj_end_d;
  logic [W-1:0]         dmaj_q, dmaj_d;
  logic [W-1:0]         dmin_q, dmin_d;
  logic [EW-1:0]        dec_q, dec_d;
  logic                 min_neg_q, min_neg_d;
  logic                 x_major_q, x_major_d;

  logic                 out_valid_q, out_valid_d;
  logic [W-1:0]         out_x_q, out_x_d;
  logic [W-1:0]         out_y_q, out_y_d;
  logic [31:0]          out_color_q, out_color_d;
  logic                 out_last_q, out_last_d;

  logic                 accept;
  logic [W-1:0]         x1, y1, x2, y2;
  logic [W:0]           dx, dy, adx_full, ady_full, dmin_sgn;
  logic [W-1:0]         adx, ady;
  logic                 ld_x_major, ld_swap;
  logic [W-1:0]         ld_dmaj, ld_dmin;
  logic [W-1:0]         cur_maj, minor_step;
  logic                 is_last;
  logic [EW-1:0]        two_dmin, two_dmaj;

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  assign x1 = s_axis_tdata_i[W-1:0];
  assign y1 = s_axis_tdata_i[2*W-1:W];
  assign x2 = s_axis_tdata_i[3*W-1:2*W];
  assign y2 = s_axis_tdata_i[4*W-1:3*W];

  // load: deltas, major axis, ordering
  always_comb begin
    dx         = {x2[W-1], x2} - {x1[W-1], x1};
    dy         = {y2[W-1], y2} - {y1[W-1], y1};
    adx_full   = dx[W] ? (~dx + 1'b1) : dx;
    ady_full   = dy[W] ? (~dy + 1'b1) : dy;
    adx        = adx_full[W-1:0];
    ady        = ady_full[W-1:0];
    ld_x_major = ady < adx;
    ld_swap    = ld_x_major ? dx[W] : dy[W];
    ld_dmaj    = ld_x_major ? adx : ady;
    ld_dmin    = ld_x_major ? ady : adx;
    dmin_sgn   = ld_x_major ? dy : dx;
  end

  assign cur_maj    = x_major_q ? cur_x_q : cur_y_q;
  assign is_last    = cur_maj == maj_end_q;
  assign minor_step = min_neg_q ? {W{1'b1}} : {{(W-1){1'b0}}, 1'b1};
  assign two_dmin   = {2'b00, dmin_q, 1'b0};
  assign two_dmaj   = {2'b00, dmaj_q, 1'b0};

  always_comb begin
    active_d    = active_q;
    cur_x_d     = cur_x_q;
    cur_y_d     = cur_y_q;
    maj_end_d   = maj_end_q;
    dmaj_d      = dmaj_q;
    dmin_d      = dmin_q;
    dec_d       = dec_q;
    min_neg_d   = min_neg_q;
    x_major_d   = x_major_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_x_d     = out_x_q;
    out_y_d     = out_y_q;
    out_color_d = out_color_q;
    out_last_d  = out_last_q;
    if (accept) begin
      if (s_axis_tuser_i == ReqLoad) begin
        x_major_d = ld_x_major;
        dmaj_d    = ld_dmaj;
        dmin_d    = ld_dmin;
        min_neg_d = (dmin_sgn[W] ^ ld_swap) && (dmin_sgn != '0);
        dec_d     = {2'b00, ld_dmin, 1'b0} - {3'b000, ld_dmaj};
        cur_x_d   = ld_swap ? x2 : x1;
        cur_y_d   = ld_swap ? y2 : y1;
        if (ld_x_major) begin
          maj_end_d = ld_swap ? x1 : x2;
        end else begin
          maj_end_d = ld_swap ? y1 : y2;
        end
        active_d  = 1'b1;
      end else if (active_q) begin
        out_valid_d = 1'b1;
        out_x_d     = cur_x_q;
        out_y_d     = cur_y_q;
        out_color_d = color_q;
        out_last_d  = is_last;
        if (is_last) begin
          active_d = 1'b0;
        end else begin
          if (dec_q[EW-1]) begin
            dec_d = dec_q + two_dmin;
          end else begin
            dec_d = dec_q + two_dmin - two_dmaj;
            if (x_major_q) begin
              cur_y_d = cur_y_q + minor_step;
            end else begin
              cur_x_d = cur_x_q + minor_step;
            end
          end
          if (x_major_q) begin
            cur_x_d = cur_x_q + {{(W-1){1'b0}}, 1'b1};
          end else begin
            cur_y_d = cur_y_q + {{(W-1){1'b0}}, 1'b1};
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_q     <= ColorReset;
      active_q    <= 1'b0;
      cur_x_q     <= '0;
      cur_y_q     <= '0;
      maj_end_q   <= '0;
      dmaj_q      <= '0;
      dmin_q      <= '0;
      dec_q       <= '0;
      min_neg_q   <= 1'b0;
      x_major_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        color_q <= cfg_wdata_i;
      end
      active_q    <= active_d;
      cur_x_q     <= cur_x_d;
      cur_y_q     <= cur_y_d;
      maj_end_q   <= maj_end_d;
      dmaj_q      <= dmaj_d;
      dmin_q      <= dmin_d;
      dec_q       <= dec_d;
      min_neg_q   <= min_neg_d;
      x_major_q   <= x_major_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_x_q     <= out_x_d;
    out_y_q     <= out_y_d;
    out_color_q <= out_color_d;
    out_last_q  <= out_last_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tdata_o  = OutDataWidth'({out_color_q, out_y_q, out_x_q});

endmodule

`default_nettype wire
